/* hw/rtl/selective_repeat_sender_window_top_defines.svh */
// Assertion helpers shared by the checking code of the sender window.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_TOP_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define SRSW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define SRSW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/srsw_pkg.sv */
package srsw_pkg;

  // Window geometry
  localparam int WINDOW = 10;
  localparam int SLOT_W = $clog2(WINDOW);

  // Field widths
  localparam int SEQ_W = 16;
  localparam int ACK_W = 17;
  localparam int ACT_W = 2;

  // Ack slot reduction: reciprocal multiply, exact for every SEQ_W-bit value
  localparam int MOD_SH  = SEQ_W + SLOT_W;
  localparam int RECIP_W = SEQ_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << MOD_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  // Input action codes
  localparam logic [ACT_W-1:0] ACT_START   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ACK     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TIMEOUT = 2'd2;

  // Write command from the sequencer to the slot store
  typedef struct packed {
    logic                    make;
    logic [SLOT_W-1:0]       make_idx;
    logic [SEQ_W-1:0]        seq;
    logic signed [ACK_W-1:0] ack_snap;
    logic                    mark;
    logic [SLOT_W-1:0]       mark_idx;
  } slot_cmd_t;

endpackage

/* hw/rtl/selective_repeat_sender_window_top.sv */
// Channel   Direction  Handshake               Payload
// cfg       in         cfg_valid_i/cfg_ready_o cfg_data_i (total_packets)
// in        in         in_valid_i/in_stall_o   action_i, ack_seq_i
// out       out        out_valid_o/out_stall_i send_seq_o .. last_of_run_o
//
// Start: accepted in ST_IDLE, then ST_FILL issues send requests (up to WINDOW).
// Ack: accepted in ST_IDLE, then ST_MOD marks the slot index (reciprocal multiply
// in the remainder unit), ST_CHK checks the border, then ST_SLIDE issues requests.
// Timeout: accepted in ST_IDLE, then ST_SCAN visits the slots (up to WINDOW).
// The input is taken only between items; the output register stalls the run.
// Reset clears all flags at once; no clearing pass follows reset.
`include "selective_repeat_sender_window_top_defines.svh"

module selective_repeat_sender_window_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [srsw_pkg::SEQ_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [srsw_pkg::ACT_W-1:0]        action_i,
  input  logic [srsw_pkg::SEQ_W-1:0]        ack_seq_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [srsw_pkg::SEQ_W-1:0]        send_seq_o,
  output logic                              relay_channel_o,
  output logic                              is_retransmit_o,
  output logic                              is_final_packet_o,
  output logic signed [srsw_pkg::ACK_W-1:0] carried_last_ack_o,
  output logic                              last_of_run_o
);
  import srsw_pkg::*;

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FILL  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_CHK   = 3'd3;
  localparam logic [2:0] ST_SLIDE = 3'd4;
  localparam logic [2:0] ST_SCAN  = 3'd5;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  logic [2:0]              state_q, state_d;
  logic [SEQ_W-1:0]        total_q, total_d;
  logic [SEQ_W-1:0]        next_seq_q, next_seq_d;
  logic                    source_ended_q, source_ended_d;
  logic signed [ACK_W-1:0] last_ack_q, last_ack_d;
  logic [SLOT_W-1:0]       border_q, border_d;
  logic [SLOT_W-1:0]       start_q, start_d;
  logic [SLOT_W-1:0]       idx_q, idx_d;
  logic [SEQ_W-1:0]        ack_q, ack_d;

  logic                    out_valid_q, out_valid_d;
  logic [SEQ_W-1:0]        out_seq_q;
  logic                    out_retx_q;
  logic                    out_final_q;
  logic signed [ACK_W-1:0] out_ack_q;
  logic                    out_last_q;

  logic                    in_accept;
  logic                    can_emit;
  logic                    emit;
  logic                    more;
  logic                    retx;
  logic                    ended_after;
  logic signed [ACK_W-1:0] emit_ack;
  logic [SLOT_W-1:0]       nxt_border;
  logic [WINDOW-1:0]       pend;
  logic [WINDOW-1:0]       later;
  logic [SEQ_W-1:0]        seq_src;
  logic [SEQ_W-1:0]        seq_inc;
  logic                    is_final;
  logic [SLOT_W-1:0]       rem_next;
  logic [SEQ_W-1:0]        rd_seq;
  logic signed [ACK_W-1:0] rd_last_ack;
  logic [WINDOW-1:0]       slot_valid;
  logic [WINDOW-1:0]       slot_acked;
  slot_cmd_t               cmd;

  // Shared increment and final-packet compare
  srsw_seq_unit u_seq (
    .seq_i      (seq_src),
    .total_i    (total_q),
    .seq_inc_o  (seq_inc),
    .is_final_o (is_final)
  );

  // Remainder unit for the acked slot index
  srsw_mod_unit u_mod (
    .value_i (ack_q),
    .rem_o   (rem_next)
  );

  srsw_slot_store u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .rd_idx_i      (idx_q),
    .rd_seq_o      (rd_seq),
    .rd_last_ack_o (rd_last_ack),
    .valid_o       (slot_valid),
    .acked_o       (slot_acked)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign can_emit    = ~out_valid_q | ~out_stall_i;

  // Sequence the work of one item
  always_comb begin
    state_d        = state_q;
    total_d        = cfg_valid_i ? cfg_data_i : total_q;
    next_seq_d     = next_seq_q;
    source_ended_d = source_ended_q;
    last_ack_d     = last_ack_q;
    border_d       = border_q;
    start_d        = start_q;
    idx_d          = idx_q;
    ack_d          = ack_q;
    emit           = 1'b0;
    more           = 1'b0;
    retx           = 1'b0;
    emit_ack       = last_ack_q;
    cmd            = '0;
    cmd.seq        = next_seq_q;
    cmd.ack_snap   = last_ack_q;

    pend        = slot_valid & ~slot_acked;
    later       = pend >> idx_q;
    nxt_border  = (border_q == LAST_SLOT) ? '0 : border_q + 1'b1;
    seq_src     = (state_q == ST_SCAN) ? rd_seq : next_seq_q;
    ended_after = source_ended_q | is_final;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (action_i)
            ACT_START: begin
              idx_d = '0;
              if (!source_ended_q) state_d = ST_FILL;
            end
            ACT_ACK: begin
              last_ack_d = {1'b0, ack_seq_i};
              ack_d      = ack_seq_i;
              state_d    = ST_MOD;
            end
            ACT_TIMEOUT: begin
              idx_d = '0;
              if (|pend) state_d = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        if (can_emit) begin
          emit         = 1'b1;
          cmd.make     = 1'b1;
          cmd.make_idx = idx_q;
          more         = ~ended_after & (idx_q != LAST_SLOT);
          idx_d        = idx_q + 1'b1;
          if (!more) state_d = ST_IDLE;
        end
      end
      ST_MOD: begin
        cmd.mark     = 1'b1;
        cmd.mark_idx = rem_next;
        state_d      = ST_CHK;
      end
      ST_CHK: begin
        if (slot_acked[border_q] && !source_ended_q) begin
          start_d = border_q;
          state_d = ST_SLIDE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SLIDE: begin
        if (can_emit) begin
          emit         = 1'b1;
          cmd.make     = 1'b1;
          cmd.make_idx = border_q;
          border_d     = nxt_border;
          more = ~ended_after & slot_acked[nxt_border] & (nxt_border != start_q);
          if (!more) state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (pend[idx_q]) begin
          if (can_emit) begin
            emit     = 1'b1;
            retx     = 1'b1;
            emit_ack = rd_last_ack;
            more     = |later[WINDOW-1:1];
            idx_d    = idx_q + 1'b1;
            if (!more) state_d = ST_IDLE;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Advance the source on every new packet
    if (cmd.make) begin
      next_seq_d = seq_inc;
      if (is_final) source_ended_d = 1'b1;
    end

    // Hold or drain the output register
    if (emit) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      total_q        <= SEQ_W'(1);
      next_seq_q     <= '0;
      source_ended_q <= 1'b0;
      last_ack_q     <= '1;
      border_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      total_q        <= total_d;
      next_seq_q     <= next_seq_d;
      source_ended_q <= source_ended_d;
      last_ack_q     <= last_ack_d;
      border_q       <= border_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    idx_q   <= idx_d;
    ack_q   <= ack_d;
    if (emit) begin
      out_seq_q   <= seq_src;
      out_retx_q  <= retx;
      out_final_q <= is_final;
      out_ack_q   <= emit_ack;
      out_last_q  <= ~more;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign send_seq_o         = out_seq_q;
  assign relay_channel_o    = out_seq_q[0];
  assign is_retransmit_o    = out_retx_q;
  assign is_final_packet_o  = out_final_q;
  assign carried_last_ack_o = out_ack_q;
  assign last_of_run_o      = out_last_q;

  // Checks on the sequencer
  `SRSW_ASSERT_NOW(a_slide_live, clk_i, rst_ni, state_q == ST_SLIDE, !source_ended_q, "slide after source end")
  `SRSW_ASSERT_NEXT(a_run_end, clk_i, rst_ni, emit && !more, state_q == ST_IDLE, "run did not end")
  `SRSW_ASSERT_NOW(a_border, clk_i, rst_ni, 1'b1, border_q <= LAST_SLOT, "border slot out of range")
  `SRSW_ASSERT_NEXT(a_ack_mod, clk_i, rst_ni, in_accept && action_i == ACT_ACK, state_q == ST_MOD, "ack not reduced")

endmodule

/* hw/rtl/srsw_seq_unit.sv */
module srsw_seq_unit (
  input  logic [srsw_pkg::SEQ_W-1:0] seq_i,
  input  logic [srsw_pkg::SEQ_W-1:0] total_i,
  output logic [srsw_pkg::SEQ_W-1:0] seq_inc_o,
  output logic                       is_final_o
);
  import srsw_pkg::*;

  logic [SEQ_W:0] sum;

  // Increment without wrap for the final test, wrap for the next sequence
  always_comb begin
    sum        = {1'b0, seq_i} + 1'b1;
    seq_inc_o  = sum[SEQ_W-1:0];
    is_final_o = (sum >= {1'b0, total_i});
  end

endmodule

/* hw/rtl/srsw_mod_unit.sv */
module srsw_mod_unit (
  input  logic [srsw_pkg::SEQ_W-1:0]  value_i,
  output logic [srsw_pkg::SLOT_W-1:0] rem_o
);
  import srsw_pkg::*;

  localparam int                PROD_W = RECIP_W + SEQ_W;
  localparam logic [SLOT_W-1:0] WIN_L  = SLOT_W'(WINDOW);

  logic [PROD_W-1:0] prod;
  logic [SLOT_W-1:0] quo_lo;
  logic [SLOT_W-1:0] back;

  // Quotient by reciprocal multiply; the remainder needs only the low bits
  always_comb begin
    prod   = {{SEQ_W{1'b0}}, RECIP} * {{RECIP_W{1'b0}}, value_i};
    quo_lo = SLOT_W'(prod >> MOD_SH);
    back   = quo_lo * WIN_L;
    rem_o  = value_i[SLOT_W-1:0] - back;
  end

endmodule

/* hw/rtl/srsw_slot_store.sv */
module srsw_slot_store (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  srsw_pkg::slot_cmd_t               cmd_i,
  input  logic [srsw_pkg::SLOT_W-1:0]       rd_idx_i,
  output logic [srsw_pkg::SEQ_W-1:0]        rd_seq_o,
  output logic signed [srsw_pkg::ACK_W-1:0] rd_last_ack_o,
  output logic [srsw_pkg::WINDOW-1:0]       valid_o,
  output logic [srsw_pkg::WINDOW-1:0]       acked_o
);
  import srsw_pkg::*;

  logic [WINDOW-1:0]       valid_q;
  logic [WINDOW-1:0]       acked_q;
  logic [SEQ_W-1:0]        seq_q      [WINDOW];
  logic signed [ACK_W-1:0] last_ack_q [WINDOW];

  // Update slot flags: a new packet is valid and unacked, an ack marks its slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      acked_q <= '0;
    end else begin
      if (cmd_i.make) begin
        valid_q[cmd_i.make_idx] <= 1'b1;
        acked_q[cmd_i.make_idx] <= 1'b0;
      end
      if (cmd_i.mark) begin
        acked_q[cmd_i.mark_idx] <= 1'b1;
      end
    end
  end

  // Store packet contents
  always_ff @(posedge clk_i) begin
    if (cmd_i.make) begin
      seq_q[cmd_i.make_idx]      <= cmd_i.seq;
      last_ack_q[cmd_i.make_idx] <= cmd_i.ack_snap;
    end
  end

  assign rd_seq_o      = seq_q[rd_idx_i];
  assign rd_last_ack_o = last_ack_q[rd_idx_i];
  assign valid_o       = valid_q;
  assign acked_o       = acked_q;

endmodule
